[rtl/core/utfx_pkg.sv]
// ----------------------------------------------------------------------------
// utfx_pkg
// Shared types and codes for the UTF-16 / UTF-32 transcoder: configuration
// register indexes, mode codes and the result and job records that travel
// from the front end through the job queue to the back end.
// ----------------------------------------------------------------------------
package utfx_pkg;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_CONV_MODE = 1'b0,
        CFG_SWAP_MODE = 1'b1
    } t_cfg_idx;

    // Conversion modes. The unused code behaves as validation.
    typedef enum logic [1:0] {
        CONV_VALIDATE = 2'd0,
        CONV_16TO32   = 2'd1,
        CONV_32TO16   = 2'd2
    } t_conv_mode;

    // Byte swap selection. The unused code means no swap.
    typedef enum logic [1:0] {
        SWAP_NONE = 2'd0,
        SWAP_IN   = 2'd1,
        SWAP_OUT  = 2'd2
    } t_swap_mode;

    localparam int CFG_DATA_W = 2;

    localparam logic [15:0] REPL_CHAR = 16'hFFFD;

    // One output beat.
    typedef struct packed {
        logic [31:0] unit;
        logic        replaced;
        logic        leftover;
        logic        last;
    } t_res;

    // Work for the back end: one or two output beats.
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_job;

endpackage

[rtl/core/utf16_utf32_transcoder_core.sv]
// ----------------------------------------------------------------------------
// utf16_utf32_transcoder_core
// Streaming UTF-16 / UTF-32 transcoder with surrogate pairing, replacement
// of malformed units and optional byte swap of input or output units.
// ----------------------------------------------------------------------------
// Usage:
// One code unit enters per input beat (i_in_valid, o_in_stall) on
// i_unit_in with i_end_of_input marking the last unit of a run. Results
// leave one per output beat (o_out_valid, i_out_stall) as o_unit_out with
// the o_replaced, o_leftover and o_last_out flags. An item yields zero,
// one or two beats; a high surrogate in the middle of a run yields none
// until the next unit shows whether it is paired.
// The first beat of an item passes through the job queue and then the
// output register.
// Throughput: one input beat per cycle while o_in_stall is low and one output
// beat per cycle while i_out_stall is low; an item that splits into two beats
// holds the output stage for both beats, so the output register sets the sustained rate.
// A queue of JOB_DEPTH jobs sits between the classifying front end and
// the output back end; o_in_stall is high only while that queue is full,
// which happens when the receiver stalls for long enough or when a run of
// items that each split into two beats outpaces the output stage.
// Configuration is written through i_cfg_valid/o_cfg_ready while the block
// is idle; any write drops a held high surrogate. After reset the mode is
// UTF-16 to UTF-32 with no swap, nothing is held and no beat is pending.
// ----------------------------------------------------------------------------
module utf16_utf32_transcoder_core #(
    parameter int JOB_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [0:0]                      i_cfg_index,
    input  logic [utfx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [31:0]                     i_unit_in,
    input  logic                            i_end_of_input,
    // Output channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [31:0]                     o_unit_out,
    output logic                            o_replaced,
    output logic                            o_leftover,
    output logic                            o_last_out
);
    import utfx_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    t_job job_in;
    t_job job_head;
    t_res res;

    // Users must issue writes only while idle; unchecked; the port always takes them.
    assign o_cfg_ready = 1'b1;

    // The input side stalls only when the job queue has no room.
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    utfx_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_unit_in      (i_unit_in),
        .i_end_of_input (i_end_of_input),
        .o_push         (push),
        .o_job          (job_in)
    );

    utfx_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    utfx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (job_head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_unit_out = res.unit;
    assign o_replaced = res.replaced;
    assign o_leftover = res.leftover;
    assign o_last_out = res.last;

`ifndef SYNTHESIS
    a_leftover_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_leftover) |-> (!o_replaced && o_last_out))
        else $error("leftover beat is not a clean final beat");
`endif

endmodule

[rtl/core/utfx_front.sv]
// ----------------------------------------------------------------------------
// utfx_front
// Front end: holds the configuration and the pending high surrogate,
// classifies each accepted code unit and builds a job of one or two beats.
// ----------------------------------------------------------------------------
module utfx_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [0:0]                          i_cfg_index,
    input  logic [utfx_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  logic [31:0]                         i_unit_in,
    input  logic                                i_end_of_input,
    output logic                                o_push,
    output utfx_pkg::t_job                      o_job
);
    import utfx_pkg::*;

    logic [1:0]  r_conv, n_conv;
    logic [1:0]  r_swap, n_swap;
    logic [15:0] r_held_high, n_held_high;
    logic        r_held_valid, n_held_valid;

    logic [31:0] ch32;
    logic [15:0] ch16;
    logic        is_hi, is_lo, is_sur;
    logic        to32, m32, out_sw;
    logic [20:0] v21;
    logic [20:0] cp;
    t_res        nw;
    logic        nw_v;
    t_job        job;
    logic        cnt_nz;

    function automatic logic [15:0] bswap16(input logic [15:0] x);
        return {x[7:0], x[15:8]};
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Sixteen-bit output unit, zero-extended, swapped on request.
    function automatic logic [31:0] out16(input logic [15:0] x, input logic sw);
        return sw ? {16'h0000, bswap16(x)} : {16'h0000, x};
    endfunction

    function automatic logic [31:0] out32(input logic [31:0] x, input logic sw);
        return sw ? bswap32(x) : x;
    endfunction

    function automatic logic [31:0] wide_out(input logic [15:0] x, input logic w,
                                             input logic sw);
        return w ? out32({16'h0000, x}, sw) : out16(x, sw);
    endfunction

    always_comb begin
        ch32   = (r_swap == SWAP_IN) ? bswap32(i_unit_in) : i_unit_in;
        ch16   = (r_swap == SWAP_IN) ? bswap16(i_unit_in[15:0]) : i_unit_in[15:0];
        is_hi  = (ch16[15:10] == 6'b110110);
        is_lo  = (ch16[15:10] == 6'b110111);
        is_sur = (ch16[15:11] == 5'b11011);
        to32   = (r_conv == CONV_16TO32);
        m32    = (r_conv == CONV_32TO16);
        out_sw = (r_swap == SWAP_OUT);
        v21    = ch32[20:0] - 21'h10000;
        cp     = 21'h10000 + {1'b0, r_held_high[9:0], ch16[9:0]};

        // Result for the new unit as if nothing were held.
        nw   = '0;
        nw_v = 1'b0;
        if (!is_sur) begin
            nw_v    = 1'b1;
            nw.unit = wide_out(ch16, to32, out_sw);
        end else if (is_lo) begin
            nw_v        = 1'b1;
            nw.unit     = wide_out(REPL_CHAR, to32, out_sw);
            nw.replaced = 1'b1;
        end else if (i_end_of_input) begin
            // Unconsumed trailing high surrogate goes out exactly as received.
            nw_v        = 1'b1;
            nw.unit     = {16'h0000, i_unit_in[15:0]};
            nw.leftover = 1'b1;
        end

        job    = '0;
        cnt_nz = 1'b1;
        if (m32) begin
            if (ch32[31:16] == 16'h0000) begin
                job.r0.unit = out16(ch32[15:0], out_sw);
            end else if (ch32 <= 32'h0010FFFF) begin
                job.two     = 1'b1;
                job.r0.unit = out16({6'b110110, v21[19:10]}, out_sw);
                job.r1.unit = out16({6'b110111, v21[9:0]}, out_sw);
            end else begin
                job.r0.unit     = out16(REPL_CHAR, out_sw);
                job.r0.replaced = 1'b1;
            end
        end else if (r_held_valid && is_lo) begin
            if (to32) begin
                job.r0.unit = out32({11'h000, cp}, out_sw);
            end else begin
                job.two     = 1'b1;
                job.r0.unit = out16(r_held_high, out_sw);
                job.r1.unit = out16(ch16, out_sw);
            end
        end else if (r_held_valid) begin
            // The held high surrogate had no partner.
            job.r0.unit     = wide_out(REPL_CHAR, to32, out_sw);
            job.r0.replaced = 1'b1;
            job.two         = nw_v;
            job.r1          = nw;
        end else begin
            job.r0 = nw;
            cnt_nz = nw_v;
        end

        if (i_end_of_input) begin
            if (job.two) begin
                job.r1.last = 1'b1;
            end else begin
                job.r0.last = 1'b1;
            end
        end
    end

    always_comb begin
        n_conv       = r_conv;
        n_swap       = r_swap;
        n_held_valid = r_held_valid;
        n_held_high  = r_held_high;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CONV_MODE: n_conv = i_cfg_data;
                CFG_SWAP_MODE: n_swap = i_cfg_data;
            endcase
            n_held_valid = 1'b0;
            n_held_high  = '0;
        end else if (i_accept && !m32) begin
            n_held_valid = is_hi && !i_end_of_input;
            n_held_high  = (is_hi && !i_end_of_input) ? ch16 : 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv       <= CONV_16TO32;
            r_swap       <= SWAP_NONE;
            r_held_valid <= 1'b0;
            r_held_high  <= '0;
        end else begin
            r_conv       <= n_conv;
            r_swap       <= n_swap;
            r_held_valid <= n_held_valid;
            r_held_high  <= n_held_high;
        end
    end

    assign o_push = i_accept && cnt_nz;
    assign o_job  = job;

`ifndef SYNTHESIS
    a_held_is_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_held_high[15:10] == 6'b110110))
        else $error("held unit is not a high surrogate");
`endif

endmodule

[rtl/core/utfx_fifo.sv]
// ----------------------------------------------------------------------------
// utfx_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module utfx_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  utfx_pkg::t_job i_job,
    input  logic           i_pop,
    output utfx_pkg::t_job o_head,
    output logic           o_empty,
    output logic           o_full
);
    import utfx_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job popped from an empty queue");
`endif

endmodule

[rtl/core/utfx_back.sv]
// ----------------------------------------------------------------------------
// utfx_back
// Back end: takes jobs from the queue and sends their one or two beats
// through a registered output stage.
// ----------------------------------------------------------------------------
module utfx_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  utfx_pkg::t_job i_head,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output utfx_pkg::t_res o_res
);
    import utfx_pkg::*;

    logic r_out_valid, n_out_valid;
    t_res r_out, n_out;
    logic r_pend_valid, n_pend_valid;
    t_res r_pend, n_pend;
    logic load;

    always_comb begin
        load         = !r_out_valid || !i_out_stall;
        o_pop        = load && !r_pend_valid && !i_empty;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (load) begin
            if (r_pend_valid) begin
                // Second beat of the current job.
                n_out_valid  = 1'b1;
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end else if (!i_empty) begin
                n_out_valid  = 1'b1;
                n_out        = i_head.r0;
                n_pend_valid = i_head.two;
                n_pend       = i_head.r1;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("second beat pending with no first beat shown");
`endif

endmodule
